[design/basx_pkg.sv]
`timescale 1ns / 1ps

package basx_pkg;

    // Clamp limits on the programmed dimensions
    localparam int MAX_INTERVALS = 64;
    localparam int MAX_STATE_DIM = 16;
    localparam int MAX_INPUT_DIM = 16;

    // Field and counter widths
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int TOL_W       = 31;
    localparam int DIM_W       = 5;
    localparam int NI_W        = 7;
    localparam int POS_W       = 6;
    localparam int FREE_W      = 12;
    localparam int SLOT_W      = 6;
    localparam int ACC_W       = 63;
    localparam int SQ_W        = 64;

    localparam logic [NI_W-1:0]   INTERVAL_SAT = {NI_W{1'b1}};
    localparam logic [FREE_W-1:0] FREE_SAT     = {FREE_W{1'b1}};
    localparam logic [SLOT_W-1:0] SLOT_SAT     = {SLOT_W{1'b1}};
    localparam logic [ACC_W-1:0]  ACC_MAX      = {ACC_W{1'b1}};

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_TOLERANCE     = 2'd0,
        REG_STATE_DIM     = 2'd1,
        REG_INPUT_DIM     = 2'd2,
        REG_NUM_INTERVALS = 2'd3
    } t_reg_idx;

    // Variable classification
    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_LOWER = 2'd1,
        ST_UPPER = 2'd2
    } t_status;

    // Clamped configuration as seen by the datapath
    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
        logic [DIM_W-1:0] state_dim;
        logic [POS_W-1:0] span;
        logic [NI_W-1:0]  num_intervals;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] point_value;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] gradient_value;
        logic signed [31:0] hessian_product;
        logic               last_var;
    } t_in_item;

    // Between classification and accumulation
    typedef struct packed {
        logic [1:0]         status;
        logic [FREE_W-1:0]  free_count;
        logic signed [31:0] neg_residual;
        logic [NI_W-1:0]    interval_number;
        logic               prev_group_valid;
        logic [SLOT_W-1:0]  prev_group_slot;
        logic [SLOT_W-1:0]  prev_group_entry;
        logic               cur_group_valid;
        logic [SLOT_W-1:0]  cur_group_slot;
        logic [SLOT_W-1:0]  cur_group_entry;
        logic [SQ_W-1:0]    residual_sq;
        logic [SQ_W-1:0]    gradient_sq;
        logic               last_var;
    } t_mid_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [FREE_W-1:0]  free_count;
        logic signed [31:0] neg_residual;
        logic [NI_W-1:0]    interval_number;
        logic               prev_group_valid;
        logic [SLOT_W-1:0]  prev_group_slot;
        logic [SLOT_W-1:0]  prev_group_entry;
        logic               cur_group_valid;
        logic [SLOT_W-1:0]  cur_group_slot;
        logic [SLOT_W-1:0]  cur_group_entry;
        logic [ACC_W-1:0]   residual_norm_sq;
        logic [ACC_W-1:0]   gradient_norm_sq;
    } t_out_item;

endpackage

[design/basx_cfg.sv]
`timescale 1ns / 1ps

module basx_cfg
    import basx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [TOL_W-1:0] r_tolerance;
    logic [DIM_W-1:0] r_state_dim;
    logic [DIM_W-1:0] r_input_dim;
    logic [NI_W-1:0]  r_num_intervals;
    t_reg_idx         reg_idx;
    logic             wr_en;
    logic [DIM_W-1:0] sd_clamped;
    logic [DIM_W-1:0] id_clamped;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register writes, one word per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance     <= TOL_W'(66);
            r_state_dim     <= DIM_W'(4);
            r_input_dim     <= DIM_W'(2);
            r_num_intervals <= NI_W'(16);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TOLERANCE:     r_tolerance     <= pwdata[TOL_W-1:0];
                REG_STATE_DIM:     r_state_dim     <= pwdata[DIM_W-1:0];
                REG_INPUT_DIM:     r_input_dim     <= pwdata[DIM_W-1:0];
                REG_NUM_INTERVALS: r_num_intervals <= pwdata[NI_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the raw register values
    always_comb begin
        unique case (reg_idx)
            REG_TOLERANCE:     prdata = {{(CFG_DATA_W-TOL_W){1'b0}}, r_tolerance};
            REG_STATE_DIM:     prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, r_state_dim};
            REG_INPUT_DIM:     prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, r_input_dim};
            REG_NUM_INTERVALS: prdata = {{(CFG_DATA_W-NI_W){1'b0}}, r_num_intervals};
            default:           prdata = '0;
        endcase
    end

    // Clamp dimensions into their legal ranges
    always_comb begin
        if (r_state_dim == '0) begin
            sd_clamped = DIM_W'(1);
        end else if (int'(r_state_dim) > MAX_STATE_DIM) begin
            sd_clamped = DIM_W'(MAX_STATE_DIM);
        end else begin
            sd_clamped = r_state_dim;
        end

        if (int'(r_input_dim) > MAX_INPUT_DIM) begin
            id_clamped = DIM_W'(MAX_INPUT_DIM);
        end else begin
            id_clamped = r_input_dim;
        end

        o_cfg.tolerance = r_tolerance;
        o_cfg.state_dim = sd_clamped;
        o_cfg.span      = {1'b0, sd_clamped} + {1'b0, id_clamped};

        if (r_num_intervals == '0) begin
            o_cfg.num_intervals = NI_W'(1);
        end else if (int'(r_num_intervals) > MAX_INTERVALS) begin
            o_cfg.num_intervals = NI_W'(MAX_INTERVALS);
        end else begin
            o_cfg.num_intervals = r_num_intervals;
        end
    end

endmodule

[design/basx_classify.sv]
`timescale 1ns / 1ps

module basx_classify
    import basx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    input  logic      i_next_ready,
    output logic      o_mid_valid,
    output t_mid_item o_mid
);

    // Pipeline registers
    logic      r_in_v;
    t_in_item  r_in;
    logic      r_mid_v;
    t_mid_item r_mid;

    // Per-pass counters; only the current and previous groups are ever touched,
    // because the interval number never goes back within a pass
    logic [POS_W-1:0]  r_pos;
    logic [NI_W-1:0]   r_interval;
    logic [FREE_W-1:0] r_free;
    logic [SLOT_W-1:0] r_cur_fill;
    logic [SLOT_W-1:0] r_prev_fill;

    logic [POS_W-1:0]  n_pos;
    logic [NI_W-1:0]   n_interval;
    logic [FREE_W-1:0] n_free;
    logic [SLOT_W-1:0] n_cur_fill;
    logic [SLOT_W-1:0] n_prev_fill;
    t_mid_item         n_mid;

    logic mid_free;
    logic in_free;
    logic in_accept;
    logic in_move;

    // Handshake
    assign mid_free    = !r_mid_v || i_next_ready;
    assign in_free     = !r_in_v || mid_free;
    assign in_accept   = i_in_valid && in_free;
    assign in_move     = r_in_v && mid_free;
    assign o_in_stall  = !in_free;
    assign o_mid_valid = r_mid_v;
    assign o_mid       = r_mid;

    // Datapath intermediates
    logic               pre_wrap;
    logic               pre_adv;
    logic [NI_W-1:0]    nx;
    logic [POS_W-1:0]   idx;
    logic [SLOT_W-1:0]  cur0;
    logic [SLOT_W-1:0]  prev0;
    logic [SLOT_W-1:0]  cur1;
    logic [SLOT_W-1:0]  prev1;
    logic [POS_W-1:0]   pos_inc;
    logic               post_adv;
    logic signed [32:0] d_lo;
    logic signed [32:0] d_up;
    logic [32:0]        m_lo;
    logic [32:0]        m_up;
    logic               lo_act;
    logic               up_act;
    logic               is_free;
    logic signed [32:0] res_sum;
    logic signed [33:0] neg_sum;
    logic [32:0]        m_res;
    logic [31:0]        m_grad;
    logic [SQ_W-1:0]    sq_res;
    logic [SQ_W-1:0]    sq_grad;
    logic               pv;
    logic               cv;
    logic [POS_W:0]     pe_wide;

    always_comb begin
        // Position beyond the span after a reprogram: wrap first
        pre_wrap = r_pos >= i_cfg.span;
        pre_adv  = pre_wrap && (r_interval != INTERVAL_SAT);
        nx       = pre_adv ? r_interval + NI_W'(1) : r_interval;
        idx      = pre_wrap ? '0 : r_pos;
        cur0     = pre_adv ? '0 : r_cur_fill;
        prev0    = pre_adv ? r_cur_fill : r_prev_fill;

        // Activity against each bound
        d_lo   = {r_in.point_value[31], r_in.point_value}
               - {r_in.lower_bound[31], r_in.lower_bound};
        d_up   = {r_in.point_value[31], r_in.point_value}
               - {r_in.upper_bound[31], r_in.upper_bound};
        m_lo   = d_lo[32] ? 33'(-d_lo) : 33'(d_lo);
        m_up   = d_up[32] ? 33'(-d_up) : 33'(d_up);
        lo_act = m_lo < {2'b00, i_cfg.tolerance};
        up_act = m_up < {2'b00, i_cfg.tolerance};
        is_free = !lo_act && !up_act;

        // Residual and squares
        res_sum = {r_in.gradient_value[31], r_in.gradient_value}
                + {r_in.hessian_product[31], r_in.hessian_product};
        neg_sum = -{res_sum[32], res_sum};
        m_res   = res_sum[32] ? 33'(-res_sum) : 33'(res_sum);
        m_grad  = r_in.gradient_value[31] ? 32'(-r_in.gradient_value)
                                          : 32'(r_in.gradient_value);
        if (!is_free) begin
            sq_res = '0;
        end else if (m_res[32]) begin
            sq_res = {SQ_W{1'b1}};
        end else begin
            sq_res = m_res[31:0] * m_res[31:0];
        end
        sq_grad = is_free ? m_grad * m_grad : '0;

        // Group slots
        pv      = is_free && ({1'b0, idx} < {2'b00, i_cfg.state_dim})
                  && (nx != '0) && ((nx - NI_W'(1)) < i_cfg.num_intervals);
        cv      = is_free && (nx < i_cfg.num_intervals);
        pe_wide = {1'b0, i_cfg.span} + {1'b0, idx};
        cur1    = (cv && cur0 != SLOT_SAT) ? cur0 + SLOT_W'(1) : cur0;
        prev1   = (pv && prev0 != SLOT_SAT) ? prev0 + SLOT_W'(1) : prev0;
        n_free  = (is_free && r_free != FREE_SAT) ? r_free + FREE_W'(1) : r_free;

        // Result fields
        if (lo_act) begin
            n_mid.status = ST_LOWER;
        end else if (up_act) begin
            n_mid.status = ST_UPPER;
        end else begin
            n_mid.status = ST_FREE;
        end
        n_mid.free_count = n_free;
        if (!is_free) begin
            n_mid.neg_residual = '0;
        end else if (!neg_sum[33] && (neg_sum[32] || neg_sum[31])) begin
            n_mid.neg_residual = 32'sh7FFF_FFFF;
        end else if (neg_sum[33] && !(neg_sum[32] && neg_sum[31])) begin
            n_mid.neg_residual = 32'sh8000_0000;
        end else begin
            n_mid.neg_residual = neg_sum[31:0];
        end
        n_mid.interval_number  = nx;
        n_mid.prev_group_valid = pv;
        n_mid.prev_group_slot  = pv ? prev0 : '0;
        n_mid.prev_group_entry = pv ? pe_wide[SLOT_W-1:0] : '0;
        n_mid.cur_group_valid  = cv;
        n_mid.cur_group_slot   = cv ? cur0 : '0;
        n_mid.cur_group_entry  = cv ? idx : '0;
        n_mid.residual_sq      = sq_res;
        n_mid.gradient_sq      = sq_grad;
        n_mid.last_var         = r_in.last_var;

        // Advance the position after the item
        pos_inc  = idx + POS_W'(1);
        post_adv = (pos_inc >= i_cfg.span) && (nx != INTERVAL_SAT);
        if (r_in.last_var) begin
            n_pos       = '0;
            n_interval  = '0;
            n_cur_fill  = '0;
            n_prev_fill = '0;
        end else begin
            n_pos       = (pos_inc >= i_cfg.span) ? '0 : pos_inc;
            n_interval  = post_adv ? nx + NI_W'(1) : nx;
            n_cur_fill  = post_adv ? '0 : cur1;
            n_prev_fill = post_adv ? cur1 : prev1;
        end
    end

    // Valid bits and per-pass counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_mid_v     <= 1'b0;
            r_pos       <= '0;
            r_interval  <= '0;
            r_free      <= '0;
            r_cur_fill  <= '0;
            r_prev_fill <= '0;
        end else begin
            r_in_v  <= in_accept || (r_in_v && !in_move);
            r_mid_v <= in_move || (r_mid_v && !i_next_ready);
            if (in_move) begin
                r_pos       <= n_pos;
                r_interval  <= n_interval;
                r_free      <= r_in.last_var ? '0 : n_free;
                r_cur_fill  <= n_cur_fill;
                r_prev_fill <= n_prev_fill;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (in_move) begin
            r_mid <= n_mid;
        end
    end

endmodule

[design/basx_accum.sv]
`timescale 1ns / 1ps

module basx_accum
    import basx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_mid_valid,
    input  t_mid_item i_mid,
    output logic      o_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic             r_out_v;
    t_out_item        r_out;
    logic [ACC_W-1:0] r_acc_res;
    logic [ACC_W-1:0] r_acc_grad;

    logic [ACC_W-1:0] n_acc_res;
    logic [ACC_W-1:0] n_acc_grad;
    logic [ACC_W-1:0] add_res;
    logic [ACC_W-1:0] add_grad;
    logic [ACC_W:0]   sum_res;
    logic [ACC_W:0]   sum_grad;
    logic             take;

    assign o_ready     = !r_out_v || !i_out_stall;
    assign take        = i_mid_valid && o_ready;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Saturating accumulation, unsigned Q63.0
    always_comb begin
        add_res    = i_mid.residual_sq[SQ_W-1] ? ACC_MAX : i_mid.residual_sq[ACC_W-1:0];
        add_grad   = i_mid.gradient_sq[SQ_W-1] ? ACC_MAX : i_mid.gradient_sq[ACC_W-1:0];
        sum_res    = {1'b0, r_acc_res} + {1'b0, add_res};
        sum_grad   = {1'b0, r_acc_grad} + {1'b0, add_grad};
        n_acc_res  = sum_res[ACC_W] ? ACC_MAX : sum_res[ACC_W-1:0];
        n_acc_grad = sum_grad[ACC_W] ? ACC_MAX : sum_grad[ACC_W-1:0];
    end

    // Output valid and running norms; norms clear after the last variable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v    <= 1'b0;
            r_acc_res  <= '0;
            r_acc_grad <= '0;
        end else begin
            r_out_v <= take || (r_out_v && i_out_stall);
            if (take) begin
                r_acc_res  <= i_mid.last_var ? '0 : n_acc_res;
                r_acc_grad <= i_mid.last_var ? '0 : n_acc_grad;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.status           <= i_mid.status;
            r_out.free_count       <= i_mid.free_count;
            r_out.neg_residual     <= i_mid.neg_residual;
            r_out.interval_number  <= i_mid.interval_number;
            r_out.prev_group_valid <= i_mid.prev_group_valid;
            r_out.prev_group_slot  <= i_mid.prev_group_slot;
            r_out.prev_group_entry <= i_mid.prev_group_entry;
            r_out.cur_group_valid  <= i_mid.cur_group_valid;
            r_out.cur_group_slot   <= i_mid.cur_group_slot;
            r_out.cur_group_entry  <= i_mid.cur_group_entry;
            r_out.residual_norm_sq <= n_acc_res;
            r_out.gradient_norm_sq <= n_acc_grad;
        end
    end

endmodule

[design/bound_active_set_extractor_top.sv]
`timescale 1ns / 1ps

// Channel   Valid        Stall        Payload       Transfer when
// input     i_in_valid   o_in_stall   i_in_data     i_in_valid && !o_in_stall
// output    o_out_valid  i_out_stall  o_out_data    o_out_valid && !i_out_stall
// config    psel/penable pready (=1)  paddr/pwdata  psel && penable && pwrite
//
// One variable per cycle sustained while the output is not stalled; a result passes through
// the input register, the classify/square register and the accumulate/result register.
// The saturating norm add in the result stage sets the loop timing.
// Reset returns the registers to their defaults and clears all per-pass counters.
// An output stall holds occupied stages only; stall reaches the input combinationally.

module bound_active_set_extractor_top
    import basx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall
);

    t_cfg      cfg;
    logic      mid_valid;
    t_mid_item mid;
    logic      acc_ready;

    basx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    basx_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_next_ready (acc_ready),
        .o_mid_valid  (mid_valid),
        .o_mid        (mid)
    );

    basx_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_ready     (acc_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

[bench/basx_result_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration port and both streaming channels, keeps its own
// model of the extractor and compares every output transfer with the oldest
// predicted result.
module basx_result_checker
    import basx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    output int                    o_mismatch_count,
    output int                    o_pending_count
);

    localparam longint RES_MAX = 64'sd2147483647;
    localparam longint RES_MIN = -64'sd2147483648;
    localparam logic [63:0] SQ_LIMIT = 64'h0000_0000_FFFF_FFFF;

    // Programmed registers, unclamped as written
    logic [TOL_W-1:0] cfg_tol;
    logic [DIM_W-1:0] cfg_state_dim;
    logic [DIM_W-1:0] cfg_input_dim;
    logic [NI_W-1:0]  cfg_intervals;

    // Per-pass state
    logic [POS_W-1:0]  var_pos;
    logic [NI_W-1:0]   interval_cnt;
    logic [FREE_W-1:0] free_cnt;
    logic [SLOT_W-1:0] group_fill [MAX_INTERVALS];
    logic [ACC_W-1:0]  residual_norm;
    logic [ACC_W-1:0]  gradient_norm;

    t_out_item awaited_results [$];
    int        mismatches = 0;

    assign o_mismatch_count = mismatches;
    initial o_pending_count = 0;

    function automatic logic [63:0] magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Square of a magnitude; anything past 32 bits pins the square
    function automatic logic [63:0] clamped_square(input logic [63:0] m);
        if (m > SQ_LIMIT)
            return {1'b0, ACC_MAX};
        return m * m;
    endfunction

    function automatic logic [ACC_W-1:0] norm_add(input logic [ACC_W-1:0] a,
                                                   input logic [63:0] b);
        logic [63:0] addend;
        logic [63:0] total;
        addend = (b > {1'b0, ACC_MAX}) ? {1'b0, ACC_MAX} : b;
        total  = {1'b0, a} + addend;
        return (total > {1'b0, ACC_MAX}) ? ACC_MAX : total[ACC_W-1:0];
    endfunction

    task automatic clear_pass();
        var_pos       = '0;
        interval_cnt  = '0;
        free_cnt      = '0;
        residual_norm = '0;
        gradient_norm = '0;
        for (int i = 0; i < MAX_INTERVALS; i++)
            group_fill[i] = '0;
    endtask

    task automatic apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        case (t_reg_idx'(addr[3:2]))
            REG_TOLERANCE:     cfg_tol       = data[TOL_W-1:0];
            REG_STATE_DIM:     cfg_state_dim = data[DIM_W-1:0];
            REG_INPUT_DIM:     cfg_input_dim = data[DIM_W-1:0];
            REG_NUM_INTERVALS: cfg_intervals = data[NI_W-1:0];
            default: ;
        endcase
    endtask

    // Classify one variable, update norms and group slots, form its result
    task automatic classify_variable(input t_in_item v, output t_out_item r);
        int unsigned sd;
        int unsigned id;
        int unsigned ni;
        int unsigned span;
        int unsigned nx;
        int unsigned idx;
        longint      pt;
        longint      lo;
        longint      hi;
        longint      grad;
        longint      hprod;
        longint      resid;
        longint      neg;
        t_status     st;

        sd = (cfg_state_dim == 0) ? 1 :
             ((cfg_state_dim > MAX_STATE_DIM) ? MAX_STATE_DIM : cfg_state_dim);
        id = (cfg_input_dim > MAX_INPUT_DIM) ? MAX_INPUT_DIM : cfg_input_dim;
        ni = (cfg_intervals == 0) ? 1 :
             ((cfg_intervals > MAX_INTERVALS) ? MAX_INTERVALS : cfg_intervals);
        span = sd + id;
        r = '0;

        // position left past the interval by a dimension change
        if (var_pos >= span) begin
            var_pos = '0;
            if (interval_cnt < INTERVAL_SAT)
                interval_cnt++;
        end
        nx  = interval_cnt;
        idx = var_pos;

        pt    = longint'($signed(v.point_value));
        lo    = longint'($signed(v.lower_bound));
        hi    = longint'($signed(v.upper_bound));
        grad  = longint'($signed(v.gradient_value));
        hprod = longint'($signed(v.hessian_product));

        // lower bound takes precedence over upper
        if (magnitude(pt - lo) < {33'd0, cfg_tol})
            st = ST_LOWER;
        else if (magnitude(pt - hi) < {33'd0, cfg_tol})
            st = ST_UPPER;
        else
            st = ST_FREE;

        if (st == ST_FREE) begin
            resid = grad + hprod;
            neg   = -resid;
            if (neg > RES_MAX)
                neg = RES_MAX;
            if (neg < RES_MIN)
                neg = RES_MIN;
            r.neg_residual = 32'(neg);
            if (free_cnt < FREE_SAT)
                free_cnt++;
            gradient_norm = norm_add(gradient_norm, clamped_square(magnitude(grad)));
            residual_norm = norm_add(residual_norm, clamped_square(magnitude(resid)));

            // a free state also lands in the previous interval's group
            if (idx < sd && nx >= 1 && nx - 1 < ni) begin
                r.prev_group_valid = 1'b1;
                r.prev_group_slot  = group_fill[nx-1];
                r.prev_group_entry = SLOT_W'(span + idx);
                if (group_fill[nx-1] < SLOT_SAT)
                    group_fill[nx-1]++;
            end
            if (nx < ni) begin
                r.cur_group_valid = 1'b1;
                r.cur_group_slot  = group_fill[nx];
                r.cur_group_entry = SLOT_W'(idx);
                if (group_fill[nx] < SLOT_SAT)
                    group_fill[nx]++;
            end
        end

        r.status           = st;
        r.free_count       = free_cnt;
        r.interval_number  = interval_cnt;
        r.residual_norm_sq = residual_norm;
        r.gradient_norm_sq = gradient_norm;

        var_pos++;
        if (var_pos >= span) begin
            var_pos = '0;
            if (interval_cnt < INTERVAL_SAT)
                interval_cnt++;
        end
        if (v.last_var)
            clear_pass();
    endtask

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            cfg_tol       = 31'd66;
            cfg_state_dim = 5'd4;
            cfg_input_dim = 5'd2;
            cfg_intervals = 7'd16;
            clear_pass();
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                apply_register(paddr, pwdata);

            // result transfer
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("free_count", want.free_count, got.free_count);
                    compare_field("neg_residual", want.neg_residual, got.neg_residual);
                    compare_field("interval_number", want.interval_number,
                                  got.interval_number);
                    compare_field("prev_group_valid", want.prev_group_valid,
                                  got.prev_group_valid);
                    compare_field("prev_group_slot", want.prev_group_slot,
                                  got.prev_group_slot);
                    compare_field("prev_group_entry", want.prev_group_entry,
                                  got.prev_group_entry);
                    compare_field("cur_group_valid", want.cur_group_valid,
                                  got.cur_group_valid);
                    compare_field("cur_group_slot", want.cur_group_slot, got.cur_group_slot);
                    compare_field("cur_group_entry", want.cur_group_entry,
                                  got.cur_group_entry);
                    compare_field("residual_norm_sq", want.residual_norm_sq,
                                  got.residual_norm_sq);
                    compare_field("gradient_norm_sq", want.gradient_norm_sq,
                                  got.gradient_norm_sq);
                end
            end

            // variable transfer
            if (i_in_valid && !i_in_stall) begin
                classify_variable(i_in_data, want);
                awaited_results.push_back(want);
            end
        end
        o_pending_count <= awaited_results.size();
    end

endmodule

[bench/tb_bound_active_set_extractor_top.sv]
`timescale 1ns / 1ps

module tb_bound_active_set_extractor_top;
    import basx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1500;
    localparam int CALM_AFTER  = 1300;
    localparam logic [31:0] FAR_LOW  = 32'h8000_0000;
    localparam logic [31:0] FAR_HIGH = 32'h7FFF_FFFF;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;

    int mismatch_count;
    int pending_count;
    int items_sent   = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    int quiet_left   = 0;
    int gapless_left = 0;
    bit calm         = 1'b0;

    // Mirror of the programmed registers, used only to shape stimulus
    logic [TOL_W-1:0] cur_tol       = 31'd66;
    int unsigned      cur_state_dim = 4;
    int unsigned      cur_input_dim = 2;
    int unsigned      cur_intervals = 16;

    bound_active_set_extractor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    basx_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in_data        (i_in_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out_data       (o_out_data),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure: short stall bursts with quiet stretches
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (quiet_left > 0) begin
            quiet_left--;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            case ($urandom_range(0, 15))
                0, 1, 2: stall_left = $urandom_range(1, 4);
                3:       quiet_left = $urandom_range(20, 80);
                default: ;
            endcase
        end
    end

    // Offset that lands a point around the activity threshold
    function automatic logic [31:0] near_offset();
        logic [31:0] t;
        t = {1'b0, cur_tol};
        case ($urandom_range(0, 5))
            0:       return t;
            1:       return t - 32'd1;
            2:       return -t;
            3:       return 32'd1 - t;
            4:       return $urandom_range(0, t);
            default: return 32'($urandom_range(0, 8)) - 32'd4;
        endcase
    endfunction

    function automatic logic [31:0] operand_word();
        case ($urandom_range(0, 11))
            0:       return FAR_LOW;
            1:       return FAR_HIGH;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item make_variable(input bit last);
        t_in_item v;
        v.point_value     = $urandom;
        v.lower_bound     = $urandom;
        v.upper_bound     = $urandom;
        v.gradient_value  = operand_word();
        v.hessian_product = operand_word();
        v.last_var        = last;
        case ($urandom_range(0, 9))
            0, 1: v.point_value = v.lower_bound + near_offset();
            2, 3: v.point_value = v.upper_bound + near_offset();
            4: begin
                v.lower_bound = v.point_value + near_offset();
                v.upper_bound = v.point_value + near_offset();
            end
            default: ;
        endcase
        return v;
    endfunction

    // One variable transfer, with an occasional idle gap ahead of it
    task automatic send_variable(input t_in_item v);
        int gap;
        if (!calm) begin
            if (gapless_left > 0) begin
                gapless_left--;
            end else if ($urandom_range(0, 30) == 0) begin
                gapless_left = $urandom_range(20, 60);
            end else if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 4);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_fields(input logic [31:0] pt, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [31:0] grad,
                               input logic [31:0] hprod, input bit last);
        t_in_item v;
        v.point_value     = pt;
        v.lower_bound     = lo;
        v.upper_bound     = hi;
        v.gradient_value  = grad;
        v.hessian_product = hprod;
        v.last_var        = last;
        send_variable(v);
    endtask

    // Setup then access; the bus is released separately after a batch
    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_TOLERANCE:     cur_tol       = value[TOL_W-1:0];
            REG_STATE_DIM:     cur_state_dim = value[DIM_W-1:0];
            REG_INPUT_DIM:     cur_input_dim = value[DIM_W-1:0];
            REG_NUM_INTERVALS: cur_intervals = value[NI_W-1:0];
            default: ;
        endcase
    endtask

    task automatic release_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the sender off until every outstanding result has been taken
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sd;
        int unsigned id;
        int unsigned ni;
        int unsigned span;
        int unsigned vec;
        int unsigned len;
        int unsigned passes;
        int          phase;
        logic [31:0] tol;
        logic [31:0] junk;
        bit          open_end;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: thresholds, precedence, residual and norm saturation
        send_fields(32'd0, 32'd0, 32'h0010_0000, 32'h0001_0000, 32'd0, 1'b0);
        send_fields(32'h0010_0000, 32'd0, 32'h0010_0000, 32'hFFFF_0000, 32'h4000, 1'b0);
        send_fields(32'd65, 32'd0, 32'h0010_0000, 32'h0001_0000, 32'd0, 1'b0);
        send_fields(32'd66, 32'd0, 32'h0010_0000, 32'h0001_0000, 32'h8000, 1'b0);
        send_fields(32'd10, 32'd0, 32'd20, 32'd5, 32'd5, 1'b0);
        send_fields(32'd0, FAR_LOW, FAR_HIGH, FAR_LOW, FAR_LOW, 1'b0);
        send_fields(32'd0, FAR_LOW, FAR_HIGH, FAR_HIGH, FAR_HIGH, 1'b0);
        send_fields(32'd0, FAR_LOW, FAR_HIGH, FAR_LOW, FAR_HIGH, 1'b0);
        send_fields(FAR_HIGH, FAR_LOW, FAR_LOW, FAR_LOW, 32'd0, 1'b0);
        send_fields(FAR_LOW, FAR_HIGH, FAR_HIGH, FAR_LOW, FAR_LOW, 1'b0);
        send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1'b0);
        send_fields(32'd0, 32'hFFFF_FFBE, 32'h42, 32'hFFFF_FFFF, 32'd1, 1'b0);
        send_fields(32'd0, 32'hFFFF_FFBF, 32'h42, 32'd7, 32'd7, 1'b0);
        send_fields(32'd0, 32'hFFFF_FF00, 32'h41, 32'd7, 32'd7, 1'b0);

        // Shrink the interval mid-pass so the position wraps, then end the pass
        drain();
        write_register(REG_STATE_DIM, 32'd1);
        write_register(REG_INPUT_DIM, 32'd0);
        write_register(REG_NUM_INTERVALS, 32'd1);
        release_bus();
        send_fields(32'd0, FAR_LOW, FAR_HIGH, 32'h0002_0000, 32'd3, 1'b0);
        send_fields(32'd0, FAR_LOW, FAR_HIGH, 32'h0002_0000, 32'd3, 1'b1);
        send_fields(32'd0, FAR_LOW, FAR_HIGH, 32'hFFFE_0000, 32'd9, 1'b0);
        send_fields(32'd0, FAR_LOW, FAR_HIGH, 32'h0000_1000, 32'd9, 1'b0);
        send_fields(32'd0, FAR_LOW, FAR_HIGH, 32'h0000_1000, 32'd9, 1'b0);

        // Random phases, each under its own register setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain();
            if (phase == 1) begin
                // smallest span over a long pass drives the interval count to its ceiling
                sd = 0;
                id = 0;
                ni = 1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       sd = 0;
                    1:       sd = 1;
                    2:       sd = 16;
                    3:       sd = 31;
                    default: sd = $urandom_range(1, 8);
                endcase
                case ($urandom_range(0, 9))
                    0:       id = 0;
                    1:       id = 16;
                    2:       id = 31;
                    default: id = $urandom_range(0, 4);
                endcase
                case ($urandom_range(0, 9))
                    0:       ni = 0;
                    1:       ni = 1;
                    2:       ni = 64;
                    3:       ni = 127;
                    default: ni = $urandom_range(1, 12);
                endcase
            end
            case ($urandom_range(0, 9))
                0:       tol = 32'd0;
                1:       tol = 32'h7FFF_FFFF;
                2:       tol = {1'b0, 31'($urandom)};
                3:       tol = 32'd66;
                default: tol = $urandom_range(0, 32'h0010_0000);
            endcase

            // unused upper bits carry noise now and then
            junk = $urandom_range(0, 1) ? $urandom : 32'd0;
            if (phase < 2 || $urandom_range(0, 1))
                write_register(REG_TOLERANCE, {junk[31], tol[30:0]});
            if (phase < 2 || $urandom_range(0, 1))
                write_register(REG_STATE_DIM, {junk[31:5], sd[4:0]});
            if (phase < 2 || $urandom_range(0, 1))
                write_register(REG_INPUT_DIM, {junk[31:5], id[4:0]});
            if (phase < 2 || $urandom_range(0, 1))
                write_register(REG_NUM_INTERVALS, {junk[31:7], ni[6:0]});
            release_bus();

            // Vector length under the clamped setting
            sd   = (cur_state_dim == 0) ? 1 :
                   ((cur_state_dim > MAX_STATE_DIM) ? MAX_STATE_DIM : cur_state_dim);
            id   = (cur_input_dim > MAX_INPUT_DIM) ? MAX_INPUT_DIM : cur_input_dim;
            ni   = (cur_intervals == 0) ? 1 :
                   ((cur_intervals > MAX_INTERVALS) ? MAX_INTERVALS : cur_intervals);
            span = sd + id;
            vec  = span * ni;

            passes = (phase == 1) ? 1 : $urandom_range(1, 3);
            for (int p = 0; p < passes; p++) begin
                // stop near the item budget
                if (items_sent >= ITEM_TARGET)
                    break;
                case ($urandom_range(0, 9))
                    0, 1:    len = $urandom_range(1, vec + 2 * span);
                    2:       len = vec + $urandom_range(1, 150);
                    default: len = vec;
                endcase
                if (phase == 1)
                    len = 140;
                else if (len > 300)
                    len = $urandom_range(1, 300);
                // some phases stop mid-pass so the next setting inherits the position
                open_end = (p == passes - 1) && (phase != 1) && ($urandom_range(0, 4) == 0);
                for (int k = 0; k < len; k++)
                    send_variable(make_variable((k == len - 1) && !open_end));
            end
            phase++;
            if (items_sent >= CALM_AFTER)
                calm = 1'b1;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[bound_active_set_extractor_top.f]
design/basx_pkg.sv
design/basx_cfg.sv
design/basx_classify.sv
design/basx_accum.sv
design/bound_active_set_extractor_top.sv
bench/basx_result_checker.sv
bench/tb_bound_active_set_extractor_top.sv
